### src/berc_pkg.sv
package berc_pkg;

	// Widths fixed by the report format
	localparam int unsigned OUT_WIDTH      = 48;
	localparam int unsigned BLOCK_WIDTH    = 32;
	localparam int unsigned INTERVAL_WIDTH = 16;
	localparam int unsigned CFG_IDX_WIDTH  = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] REG_HOLDOFF  = 1'b0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_INTERVAL = 1'b1;

	typedef logic [INTERVAL_WIDTH-1:0] interval_t;
	typedef logic [BLOCK_WIDTH-1:0]    block_num_t;
	typedef logic [OUT_WIDTH-1:0]      out_count_t;

endpackage

### src/berc_sat_counter.sv
module berc_sat_counter #(
	parameter int unsigned      WIDTH       = 48,
	parameter logic [WIDTH-1:0] RESET_VALUE = '0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             inc,
	output logic [WIDTH-1:0] count,
	output logic [WIDTH-1:0] count_next
);

	logic [WIDTH-1:0] count_q;

	// Hold at all ones once the top is reached
	assign count_next = (inc && !(&count_q)) ? count_q + WIDTH'(1) : count_q;
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= RESET_VALUE;
		end else begin
			count_q <= count_next;
		end
	end

endmodule

### src/bit_error_rate_counter_core.sv
// Bit error rate counter.
// Report timing: a report is registered and appears on the output in the cycle after the block's last bit is taken.
// Throughput: one bit per clock; the output register decouples a stalled consumer
// by one report, after which input ready follows output ready.
// Reset: all running totals cleared, block number 1, holdoff 0, report interval 1.
module bit_error_rate_counter_core
	import berc_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// bit input channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     rx_bit,
	input  logic                     ref_bit,
	input  logic                     last_in_block,
	// report output channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [BLOCK_WIDTH-1:0]   block_number,
	output logic [OUT_WIDTH-1:0]     total_bits,
	output logic [OUT_WIDTH-1:0]     total_zeros,
	output logic [OUT_WIDTH-1:0]     total_ones,
	output logic [OUT_WIDTH-1:0]     total_errors,
	output logic [OUT_WIDTH-1:0]     space_errors,
	output logic [OUT_WIDTH-1:0]     mark_errors,
	// configuration write port
	input  logic                     cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [INTERVAL_WIDTH-1:0] cfg_data
);

	interval_t  holdoff_q;
	interval_t  interval_q;
	interval_t  to_report_q;
	interval_t  to_report_dec;
	interval_t  reload_val;
	block_num_t block_idx;
	block_num_t block_idx_next;

	logic accept;
	logic counted;
	logic bit_err;
	logic report;
	logic out_valid_q;

	logic [COUNT_WIDTH-1:0] bits_cnt,  bits_nxt;
	logic [COUNT_WIDTH-1:0] zeros_cnt, zeros_nxt;
	logic [COUNT_WIDTH-1:0] ones_cnt,  ones_nxt;
	logic [COUNT_WIDTH-1:0] err_cnt,   err_nxt;
	logic [COUNT_WIDTH-1:0] space_cnt, space_nxt;
	logic [COUNT_WIDTH-1:0] mark_cnt,  mark_nxt;

	// Handshake
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Bit classification
	assign counted = block_idx > BLOCK_WIDTH'(holdoff_q);
	assign bit_err = rx_bit ^ ref_bit;

	// Block number, starts at 1 and saturates at all ones
	berc_sat_counter #(
		.WIDTH       (BLOCK_WIDTH),
		.RESET_VALUE (BLOCK_WIDTH'(1))
	) u_block_cnt (
		.clk        (clk),
		.arst_n     (arst_n),
		.inc        (accept && last_in_block),
		.count      (block_idx),
		.count_next (block_idx_next)
	);

	// Running totals
	berc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_bits_cnt (
		.clk(clk), .arst_n(arst_n), .inc(accept && counted),
		.count(bits_cnt), .count_next(bits_nxt)
	);
	berc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_zeros_cnt (
		.clk(clk), .arst_n(arst_n), .inc(accept && counted && !ref_bit),
		.count(zeros_cnt), .count_next(zeros_nxt)
	);
	berc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_ones_cnt (
		.clk(clk), .arst_n(arst_n), .inc(accept && counted && ref_bit),
		.count(ones_cnt), .count_next(ones_nxt)
	);
	berc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_err_cnt (
		.clk(clk), .arst_n(arst_n), .inc(accept && counted && bit_err),
		.count(err_cnt), .count_next(err_nxt)
	);
	berc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_space_cnt (
		.clk(clk), .arst_n(arst_n), .inc(accept && counted && bit_err && !ref_bit),
		.count(space_cnt), .count_next(space_nxt)
	);
	berc_sat_counter #(.WIDTH(COUNT_WIDTH)) u_mark_cnt (
		.clk(clk), .arst_n(arst_n), .inc(accept && counted && bit_err && ref_bit),
		.count(mark_cnt), .count_next(mark_nxt)
	);

	// Report countdown; a zero interval behaves as one
	assign reload_val    = (interval_q == '0) ? INTERVAL_WIDTH'(1) : interval_q;
	assign to_report_dec = to_report_q - INTERVAL_WIDTH'(1);
	assign report        = accept && last_in_block && counted && (to_report_dec == '0);

	// Configuration and countdown registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q   <= '0;
			interval_q  <= INTERVAL_WIDTH'(1);
			to_report_q <= INTERVAL_WIDTH'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HOLDOFF: begin
					holdoff_q <= cfg_data;
				end
				REG_INTERVAL: begin
					interval_q  <= cfg_data;
					to_report_q <= (cfg_data == '0) ? INTERVAL_WIDTH'(1) : cfg_data;
				end
				default: begin
				end
			endcase
		end else if (accept && last_in_block && counted) begin
			to_report_q <= report ? reload_val : to_report_dec;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (report) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Report payload, totals include the bit just taken
	always_ff @(posedge clk) begin
		if (report) begin
			block_number <= block_idx;
			total_bits   <= OUT_WIDTH'(bits_nxt);
			total_zeros  <= OUT_WIDTH'(zeros_nxt);
			total_ones   <= OUT_WIDTH'(ones_nxt);
			total_errors <= OUT_WIDTH'(err_nxt);
			space_errors <= OUT_WIDTH'(space_nxt);
			mark_errors  <= OUT_WIDTH'(mark_nxt);
		end
	end

	// Current totals are only needed through their next values
	logic unused_cnt;
	assign unused_cnt = ^{bits_cnt, zeros_cnt, ones_cnt, err_cnt, space_cnt, mark_cnt,
		block_idx_next};

endmodule
